[src/qfr_pkg.sv]
// ----------------------------------------------------------------------------
// qfr_pkg
// Types and constants shared by the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package qfr_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC       = DATA_WIDTH - 2;
  localparam int CW         = DATA_WIDTH + 3;
  localparam int MW         = DATA_WIDTH + 2;
  localparam int LENW       = $clog2(MW + 1);
  localparam int NORM       = 31;
  localparam int SQW        = 2 * NORM;
  localparam int SUMW       = 64;
  localparam int ROOTW      = 32;
  localparam int ISQ_STAGES = 32;
  localparam int QB         = FRAC + 1;
  localparam int DVW        = ROOTW + QB;

  localparam logic signed [CW-1:0] ONE_C = CW'(2 ** FRAC);

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] qx;
    logic signed [DATA_WIDTH-1:0] qy;
    logic signed [DATA_WIDTH-1:0] qz;
    logic signed [DATA_WIDTH-1:0] qw;
    logic [1:0]                   branch_taken;
  } quat_t;

  typedef struct packed {
    logic [3:0][NORM-1:0] mag;
    logic [3:0]           neg;
    logic                 zero;
    branch_t              branch;
  } side_t;

endpackage

[src/qfr_front.sv]
// ----------------------------------------------------------------------------
// qfr_front
// Branch selection, unscaled quaternion, common normalizing shift and the
// sum of squares, in six register stages.
// ----------------------------------------------------------------------------
module qfr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  qfr_pkg::matrix_t           in_data,
  output logic                       out_valid,
  output qfr_pkg::side_t             out_side,
  output logic [qfr_pkg::SUMW-1:0]   out_sum
);

  localparam int CW   = qfr_pkg::CW;
  localparam int MW   = qfr_pkg::MW;
  localparam int LENW = qfr_pkg::LENW;
  localparam int NORM = qfr_pkg::NORM;
  localparam int SQW  = qfr_pkg::SQW;
  localparam int SUMW = qfr_pkg::SUMW;

  logic [5:0] vld;

  logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, t;
  qfr_pkg::branch_t     br_c;

  logic signed [CW-1:0] s1_rw, s1_rx, s1_ry, s1_rz;
  logic signed [CW-1:0] s1_d12, s1_d20, s1_d01, s1_s01, s1_s02, s1_s12;
  qfr_pkg::branch_t     s1_branch;

  logic signed [CW-1:0] c [4];
  logic [3:0][MW-1:0]   mag_c;
  logic [3:0]           neg_c;

  logic [3:0][MW-1:0]   s2_mag;
  logic [3:0]           s2_neg;
  qfr_pkg::branch_t     s2_branch;

  logic [MW-1:0]        orv;
  logic [LENW-1:0]      len_c;

  logic [3:0][MW-1:0]   s3_mag;
  logic [3:0]           s3_neg;
  logic                 s3_zero;
  logic [LENW-1:0]      s3_len;
  qfr_pkg::branch_t     s3_branch;

  logic [MW+NORM-1:0]   wide [4];
  logic [3:0][NORM-1:0] sh_c;

  logic [3:0][NORM-1:0] s4_sh;
  logic [3:0]           s4_neg;
  logic                 s4_zero;
  qfr_pkg::branch_t     s4_branch;

  logic [3:0][SQW-1:0]  s5_sq;
  logic [3:0][NORM-1:0] s5_sh;
  logic [3:0]           s5_neg;
  logic                 s5_zero;
  qfr_pkg::branch_t     s5_branch;

  logic [SUMW-1:0]      s6_sum;
  qfr_pkg::side_t       s6_side;

  always_comb begin
    e00 = CW'(in_data.m00);
    e01 = CW'(in_data.m01);
    e02 = CW'(in_data.m02);
    e10 = CW'(in_data.m10);
    e11 = CW'(in_data.m11);
    e12 = CW'(in_data.m12);
    e20 = CW'(in_data.m20);
    e21 = CW'(in_data.m21);
    e22 = CW'(in_data.m22);
    t   = e00 + e11 + e22;
    if (t > 0) begin
      br_c = qfr_pkg::BR_TRACE;
    end else if (e00 >= e11 && e00 >= e22) begin
      br_c = qfr_pkg::BR_X;
    end else if (e11 > e22) begin
      br_c = qfr_pkg::BR_Y;
    end else begin
      br_c = qfr_pkg::BR_Z;
    end
  end

  always_comb begin
    logic signed [CW-1:0] rx, ry, rz;
    rx = (s1_rx < 0) ? '0 : s1_rx;
    ry = (s1_ry < 0) ? '0 : s1_ry;
    rz = (s1_rz < 0) ? '0 : s1_rz;
    case (s1_branch)
      qfr_pkg::BR_TRACE: begin
        c[0] = s1_d12; c[1] = s1_d20; c[2] = s1_d01; c[3] = s1_rw;
      end
      qfr_pkg::BR_X: begin
        c[0] = rx; c[1] = s1_s01; c[2] = s1_s02; c[3] = s1_d12;
      end
      qfr_pkg::BR_Y: begin
        c[0] = s1_s01; c[1] = ry; c[2] = s1_s12; c[3] = s1_d20;
      end
      default: begin
        c[0] = s1_s02; c[1] = s1_s12; c[2] = rz; c[3] = s1_d01;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      neg_c[i] = c[i][CW-1];
      mag_c[i] = neg_c[i] ? MW'(-c[i]) : MW'(c[i]);
    end
  end

  always_comb begin
    orv   = s2_mag[0] | s2_mag[1] | s2_mag[2] | s2_mag[3];
    len_c = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) begin
        len_c = LENW'(i + 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wide[i] = {s3_mag[i], {NORM{1'b0}}} >> s3_len;
      sh_c[i] = wide[i][NORM-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rw     <= qfr_pkg::ONE_C + t;
      s1_rx     <= qfr_pkg::ONE_C + e00 - e11 - e22;
      s1_ry     <= qfr_pkg::ONE_C + e11 - e22 - e00;
      s1_rz     <= qfr_pkg::ONE_C + e22 - e11 - e00;
      s1_d12    <= e12 - e21;
      s1_d20    <= e20 - e02;
      s1_d01    <= e01 - e10;
      s1_s01    <= e01 + e10;
      s1_s02    <= e02 + e20;
      s1_s12    <= e12 + e21;
      s1_branch <= br_c;

      s2_mag    <= mag_c;
      s2_neg    <= neg_c;
      s2_branch <= s1_branch;

      s3_mag    <= s2_mag;
      s3_neg    <= s2_neg;
      s3_zero   <= (orv == '0);
      s3_len    <= len_c;
      s3_branch <= s2_branch;

      s4_sh     <= sh_c;
      s4_neg    <= s3_neg;
      s4_zero   <= s3_zero;
      s4_branch <= s3_branch;

      for (int i = 0; i < 4; i++) begin
        s5_sq[i] <= SQW'(s4_sh[i]) * SQW'(s4_sh[i]);
      end
      s5_sh     <= s4_sh;
      s5_neg    <= s4_neg;
      s5_zero   <= s4_zero;
      s5_branch <= s4_branch;

      s6_sum         <= SUMW'(s5_sq[0]) + SUMW'(s5_sq[1]) + SUMW'(s5_sq[2])
                        + SUMW'(s5_sq[3]);
      s6_side.mag    <= s5_sh;
      s6_side.neg    <= s5_neg;
      s6_side.zero   <= s5_zero;
      s6_side.branch <= s5_branch;
    end
  end

  assign out_valid = vld[5];
  assign out_side  = s6_side;
  assign out_sum   = s6_sum;

endmodule

[src/qfr_isqrt.sv]
// ----------------------------------------------------------------------------
// qfr_isqrt
// Integer square root of the 64-bit sum of squares, one result bit per
// register stage.
// ----------------------------------------------------------------------------
module qfr_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  qfr_pkg::side_t              in_side,
  input  logic [qfr_pkg::SUMW-1:0]    in_sum,
  output logic                        out_valid,
  output qfr_pkg::side_t              out_side,
  output logic [qfr_pkg::ROOTW-1:0]   out_root
);

  localparam int N    = qfr_pkg::ISQ_STAGES;
  localparam int SUMW = qfr_pkg::SUMW;

  typedef struct packed {
    logic [SUMW-1:0] rem;
    logic [SUMW-1:0] res;
    qfr_pkg::side_t  sd;
  } isq_t;

  logic [N-1:0] vld;
  isq_t         st [N];
  isq_t         head;

  function automatic isq_t isq_step(isq_t s, int k);
    isq_t            o;
    logic [SUMW-1:0] bitv;
    logic [SUMW-1:0] trial;
    o     = s;
    bitv  = SUMW'(1) << (SUMW - 2 - 2 * k);
    trial = s.res + bitv;
    if (s.rem >= trial) begin
      o.rem = s.rem - trial;
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  always_comb begin
    head.rem = in_sum;
    head.res = '0;
    head.sd  = in_side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= isq_step(head, 0);
      for (int k = 1; k < N; k++) begin
        st[k] <= isq_step(st[k-1], k);
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_side  = st[N-1].sd;
  assign out_root  = st[N-1].res[qfr_pkg::ROOTW-1:0];

endmodule

[src/qfr_div.sv]
// ----------------------------------------------------------------------------
// qfr_div
// Four-lane restoring divider: each magnitude scaled to Q.FRAC and rounded,
// divided by the root, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qfr_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  qfr_pkg::side_t                       in_side,
  input  logic [qfr_pkg::ROOTW-1:0]            in_root,
  output logic                                 out_valid,
  output logic [3:0][qfr_pkg::QB-1:0]          out_quo,
  output logic [3:0]                           out_neg,
  output logic                                 out_zero,
  output qfr_pkg::branch_t                     out_branch
);

  localparam int QB    = qfr_pkg::QB;
  localparam int DVW   = qfr_pkg::DVW;
  localparam int ROOTW = qfr_pkg::ROOTW;

  typedef struct packed {
    logic [3:0][DVW-1:0] rem;
    logic [ROOTW-1:0]    root;
    logic [3:0][QB-1:0]  quo;
    logic [3:0]          neg;
    logic                zero;
    qfr_pkg::branch_t    branch;
  } dst_t;

  logic [QB:0] vld;
  dst_t        st [QB+1];
  dst_t        prep;

  function automatic dst_t div_step(dst_t s, int b);
    dst_t           o;
    logic [DVW-1:0] cmp;
    o   = s;
    cmp = DVW'(s.root) << b;
    for (int i = 0; i < 4; i++) begin
      if (s.rem[i] >= cmp) begin
        o.rem[i]    = s.rem[i] - cmp;
        o.quo[i][b] = 1'b1;
      end
    end
    return o;
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prep.rem[i] = (DVW'(in_side.mag[i]) << qfr_pkg::FRAC) + DVW'(in_root >> 1);
    end
    prep.root   = in_root;
    prep.quo    = '0;
    prep.neg    = in_side.neg;
    prep.zero   = in_side.zero;
    prep.branch = in_side.branch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= prep;
      for (int k = 1; k <= QB; k++) begin
        st[k] <= div_step(st[k-1], QB - k);
      end
    end
  end

  assign out_valid  = vld[QB];
  assign out_quo    = st[QB].quo;
  assign out_neg    = st[QB].neg;
  assign out_zero   = st[QB].zero;
  assign out_branch = st[QB].branch;

endmodule

[src/quaternion_from_rotation_matrix_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_from_rotation_matrix_unit
// A result reaches quat through the front, square root, divider and output registers.
// Throughput: one matrix per cycle unless matrix_stall is high; the 32-stage
// square root and the 16-stage divider are fully pipelined.
// Reset clears all valid bits; the pipeline and output stage come up empty.
// Rotation matrix to unit quaternion by Shepperd's method, Q2.14 fixed point.
// ----------------------------------------------------------------------------
module quaternion_from_rotation_matrix_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             matrix_valid,
  output logic             matrix_stall,
  input  qfr_pkg::matrix_t matrix,
  output logic             quat_valid,
  input  logic             quat_stall,
  output qfr_pkg::quat_t   quat
);

  localparam int W  = qfr_pkg::DATA_WIDTH;
  localparam int QB = qfr_pkg::QB;
  localparam logic [W:0] POS_MAX = (W+1)'((2 ** (W - 1)) - 1);
  localparam logic [W:0] NEG_MAX = (W+1)'(2 ** (W - 1));

  logic                    en;
  logic                    fr_valid;
  qfr_pkg::side_t          fr_side;
  logic [qfr_pkg::SUMW-1:0] fr_sum;
  logic                    sq_valid;
  qfr_pkg::side_t          sq_side;
  logic [qfr_pkg::ROOTW-1:0] sq_root;
  logic                    dv_valid;
  logic [3:0][QB-1:0]      dv_quo;
  logic [3:0]              dv_neg;
  logic                    dv_zero;
  qfr_pkg::branch_t        dv_branch;

  logic [W-1:0]            q_c [4];
  logic [1:0]              own;
  logic                    fin_valid;
  qfr_pkg::quat_t          fin_data;
  logic                    skid_valid;
  qfr_pkg::quat_t          skid_data;
  logic                    fire;

  assign en           = !skid_valid;
  assign matrix_stall = skid_valid;
  assign fire         = en && fin_valid;

  qfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (matrix_valid),
    .in_data   (matrix),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_sum   (fr_sum)
  );

  qfr_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_sum    (fr_sum),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  qfr_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sq_valid),
    .in_side    (sq_side),
    .in_root    (sq_root),
    .out_valid  (dv_valid),
    .out_quo    (dv_quo),
    .out_neg    (dv_neg),
    .out_zero   (dv_zero),
    .out_branch (dv_branch)
  );

  always_comb begin
    logic [W:0] lim;
    unique case (dv_branch)
      qfr_pkg::BR_TRACE: own = 2'd3;
      qfr_pkg::BR_X:     own = 2'd0;
      qfr_pkg::BR_Y:     own = 2'd1;
      qfr_pkg::BR_Z:     own = 2'd2;
      default:           own = 2'd3;
    endcase
    for (int i = 0; i < 4; i++) begin
      lim = (W+1)'(dv_quo[i]);
      if (dv_zero) begin
        q_c[i] = (own == 2'(i)) ? W'(2 ** qfr_pkg::FRAC) : '0;
      end else if (dv_neg[i]) begin
        if (lim > NEG_MAX) begin
          lim = NEG_MAX;
        end
        q_c[i] = W'(~lim + 1'b1);
      end else begin
        if (lim > POS_MAX) begin
          lim = POS_MAX;
        end
        q_c[i] = W'(lim);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_data.qx           <= q_c[0];
      fin_data.qy           <= q_c[1];
      fin_data.qz           <= q_c[2];
      fin_data.qw           <= q_c[3];
      fin_data.branch_taken <= dv_branch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!quat_valid || !quat_stall) begin
      if (skid_valid) begin
        quat_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        quat_valid <= fire;
      end
    end else if (fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!quat_valid || !quat_stall) begin
      quat <= skid_valid ? skid_data : fin_data;
    end else if (fire) begin
      skid_data <= fin_data;
    end
  end

endmodule
